/* hdl/ussc_pkg.sv */
// Shared types, codes and a helper function for the ultrasonic sweep sector scanner.
package ussc_pkg;

    // Field widths
    localparam int ECHO_W  = 16;
    localparam int ANGLE_W = 8;
    localparam int CLASS_W = 2;
    localparam int THR_W   = 9;
    localparam int SUM_W   = 13;
    localparam int CM_W    = 11;
    localparam int MODE_W  = 2;
    localparam int SEC_W   = 2;
    localparam int IDX_W   = 1;

    // Opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_ECHO  = 1'b1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_VERY_CLOSE = 1'b0;
    localparam logic [IDX_W-1:0] REG_NEAR       = 1'b1;

    // Sweep modes
    localparam logic [MODE_W-1:0] MODE_FWD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd2;

    // Sectors
    localparam logic [SEC_W-1:0] SEC_RIGHT  = 2'd0;
    localparam logic [SEC_W-1:0] SEC_CENTER = 2'd1;
    localparam logic [SEC_W-1:0] SEC_LEFT   = 2'd2;

    // Distance classes
    localparam logic [CLASS_W-1:0] CLASS_VERY_CLOSE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_NEAR       = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FAR        = 2'd2;

    // Angles
    localparam logic [ANGLE_W-1:0] ANGLE_HOME      = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_SERVO_MIN = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_SERVO_MAX = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_FWD_END   = 8'd179;
    localparam logic [ANGLE_W-1:0] ANGLE_REV_END   = 8'd89;
    localparam logic [ANGLE_W-1:0] ANGLE_RIGHT_MAX = 8'd120;
    localparam logic [ANGLE_W-1:0] ANGLE_LEFT_MIN  = 8'd150;

    // Echo to cm: floor(us / 58) via reciprocal 65536/58 rounded down
    localparam int          US_PER_CM  = 58;
    localparam int          RECIP_SH   = 16;
    localparam logic [10:0] RECIP_MULT = 11'd1129;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Result of one beat
    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               servo_move;
        logic [CLASS_W-1:0] left_class;
        logic [CLASS_W-1:0] right_class;
        logic [CLASS_W-1:0] center_class;
        logic               step_taken;
        logic               sweep_done;
    } ussc_result_t;

    // Sector of an angle
    function automatic logic [SEC_W-1:0] sector_of(input logic [ANGLE_W-1:0] a);
        logic [SEC_W-1:0] s;
        if (a <= ANGLE_RIGHT_MAX)
            s = SEC_RIGHT;
        else if (a < ANGLE_LEFT_MIN)
            s = SEC_CENTER;
        else
            s = SEC_LEFT;
        return s;
    endfunction

endpackage

/* hdl/ussc_echo_scale.sv */
// First half of the echo-to-centimeter conversion: reciprocal multiply estimate.
module ussc_echo_scale
(
    input  logic [ussc_pkg::ECHO_W-1:0] echo_us,
    output logic [ussc_pkg::CM_W-1:0]   cm_est
);
    import ussc_pkg::*;

    logic [ECHO_W+CM_W-1:0] product;

    // Estimate is floor(us/58) or one less; the core corrects it
    assign product = (ECHO_W+CM_W)'(echo_us) * (ECHO_W+CM_W)'(RECIP_MULT);
    assign cm_est  = product[RECIP_SH +: CM_W];

endmodule

/* hdl/ussc_sweep_core.sv */
// Sweep state, per-step averaging and sector classification.
module ussc_sweep_core #(
    parameter int SAMPLES_PER_STEP = 5,
    parameter int ANGLE_STEP       = 2
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         operation,
    input  logic [ussc_pkg::ECHO_W-1:0]  echo_us,
    input  logic [ussc_pkg::CM_W-1:0]    cm_est,
    input  logic [ussc_pkg::THR_W-1:0]   very_close_cm,
    input  logic [ussc_pkg::THR_W-1:0]   near_cm,
    output ussc_pkg::ussc_result_t       result
);
    import ussc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_STEP + 1);

    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [SEC_W-1:0]   sector_reg, sector_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CLASS_W-1:0] left_reg, left_next;
    logic [CLASS_W-1:0] right_reg, right_next;
    logic [CLASS_W-1:0] center_reg, center_next;

    logic [ECHO_W-1:0]  est_us;
    logic [ECHO_W-1:0]  remainder;
    logic [CM_W-1:0]    cm;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic [CNT_W-1:0]   count_inc;
    logic [SUM_W:0]     lim_very_close;
    logic [SUM_W:0]     lim_near;
    logic [CLASS_W-1:0] step_class;
    logic [ANGLE_W-1:0] angle_stepped;
    logic [SEC_W-1:0]   sector_stepped;
    logic               active;
    logic               move;
    logic               step;

    // Finish floor(us/58): one compare and subtract on the estimate
    assign est_us    = ECHO_W'(cm_est * US_PER_CM);
    assign remainder = echo_us - est_us;
    assign cm        = (remainder >= ECHO_W'(US_PER_CM)) ? cm_est + 1'b1 : cm_est;

    // Saturating running sum
    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(cm);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    assign count_inc = count_reg + 1'b1;

    // mean < thr evaluated as sum < N*thr
    assign lim_very_close = (SUM_W+1)'(very_close_cm * SAMPLES_PER_STEP);
    assign lim_near       = (SUM_W+1)'(near_cm * SAMPLES_PER_STEP);

    always_comb
    begin
        if ({1'b0, sum_sat} < lim_very_close)
            step_class = CLASS_VERY_CLOSE;
        else if ({1'b0, sum_sat} < lim_near)
            step_class = CLASS_NEAR;
        else
            step_class = CLASS_FAR;
    end

    assign active = (mode_reg == MODE_FWD) || (mode_reg == MODE_REV);

    assign angle_stepped  = (mode_reg == MODE_FWD) ? angle_reg + ANGLE_W'(ANGLE_STEP)
                                                   : angle_reg - ANGLE_W'(ANGLE_STEP);
    assign sector_stepped = sector_of(angle_stepped);

    // Next state for one beat
    always_comb
    begin
        angle_next  = angle_reg;
        mode_next   = mode_reg;
        sector_next = sector_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        center_next = center_reg;
        move        = 1'b0;
        step        = 1'b0;

        if (operation == OP_START)
        begin
            angle_next  = ANGLE_HOME;
            mode_next   = MODE_FWD;
            sector_next = SEC_LEFT;
            count_next  = '0;
            sum_next    = '0;
            move        = 1'b1;
        end
        else if (active)
        begin
            sum_next   = sum_sat;
            count_next = count_inc;
            if (count_inc >= CNT_W'(SAMPLES_PER_STEP))
            begin
                angle_next = angle_stepped;
                move = (angle_stepped >= ANGLE_SERVO_MIN) && (angle_stepped <= ANGLE_SERVO_MAX);
                // Store the class of the sector being left
                if (sector_stepped != sector_reg)
                begin
                    case (sector_reg)
                        SEC_LEFT:  left_next   = step_class;
                        SEC_RIGHT: right_next  = step_class;
                        default:   center_next = step_class;
                    endcase
                end
                sector_next = sector_stepped;
                if (mode_reg == MODE_FWD)
                begin
                    if (angle_stepped >= ANGLE_FWD_END)
                        mode_next = MODE_REV;
                end
                else
                begin
                    if (angle_stepped <= ANGLE_REV_END)
                        mode_next = MODE_IDLE;
                end
                count_next = '0;
                sum_next   = '0;
                step       = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg  <= ANGLE_HOME;
            mode_reg   <= MODE_IDLE;
            sector_reg <= SEC_LEFT;
            count_reg  <= '0;
            sum_reg    <= '0;
            left_reg   <= CLASS_FAR;
            right_reg  <= CLASS_FAR;
            center_reg <= CLASS_FAR;
        end
        else if (fire)
        begin
            angle_reg  <= angle_next;
            mode_reg   <= mode_next;
            sector_reg <= sector_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            left_reg   <= left_next;
            right_reg  <= right_next;
            center_reg <= center_next;
        end
    end

    // Result fields reflect the state after this beat
    always_comb
    begin
        result.servo_angle  = angle_next;
        result.servo_move   = move;
        result.left_class   = left_next;
        result.right_class  = right_next;
        result.center_class = center_next;
        result.step_taken   = step;
        result.sweep_done   = !((mode_next == MODE_FWD) || (mode_next == MODE_REV));
    end

endmodule

/* hdl/ultrasonic_sweep_sector_scanner.sv */
// Top level of the ultrasonic sweep sector scanner: input register, core, result register.
//
// Input channel (in_valid/in_ready): operation 0 starts a sweep at 90 degrees,
// operation 1 delivers one echo width in echo_us (microseconds).
// Every input beat yields exactly one result beat on out_valid/out_ready with the
// servo command, the three stored sector classes, step and done flags.
// Config channel (cfg_valid/cfg_ready): cfg_index 0 writes very_close_cm,
// 1 writes near_cm; cfg_ready is always high. Write only with no beat in flight.
// Each input beat passes the input register, then the single-pass update into
// the result register.
// Throughput: one beat per cycle while the receiver does not stall, set by the single-pass state update in the core.
// The echo-to-cm reciprocal multiply runs ahead of the input register; the
// correction and sweep update run between input and result registers.
// Reset: angle 90, idle, all classes far, thresholds 20 and 50, both stages empty.
// Receiver stall: the result register holds; one more beat waits in the input
// register, after which in_ready drops until the result is taken.
module ultrasonic_sweep_sector_scanner #(
    parameter int SAMPLES_PER_STEP = 5,
    parameter int ANGLE_STEP       = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [ussc_pkg::ECHO_W-1:0]   echo_us,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ussc_pkg::ANGLE_W-1:0]  servo_angle,
    output logic                          servo_move,
    output logic [ussc_pkg::CLASS_W-1:0]  left_class,
    output logic [ussc_pkg::CLASS_W-1:0]  right_class,
    output logic [ussc_pkg::CLASS_W-1:0]  center_class,
    output logic                          step_taken,
    output logic                          sweep_done,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ussc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ussc_pkg::THR_W-1:0]    cfg_data
);
    import ussc_pkg::*;

    logic               in_valid_reg;
    logic               op_reg;
    logic [ECHO_W-1:0]  us_reg;
    logic [CM_W-1:0]    cm_est_reg;
    logic [CM_W-1:0]    cm_est;
    logic               out_valid_reg;
    ussc_result_t       result_reg;
    ussc_result_t       result;
    logic [THR_W-1:0]   very_close_reg;
    logic [THR_W-1:0]   near_reg;
    logic               advance;
    logic               fire;
    logic               in_beat;

    // Pipeline control
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_beat  = in_valid && in_ready;

    ussc_echo_scale u_scale
    (
        .echo_us (echo_us),
        .cm_est  (cm_est)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg     <= operation;
            us_reg     <= echo_us;
            cm_est_reg <= cm_est;
        end
    end

    ussc_sweep_core #(
        .SAMPLES_PER_STEP (SAMPLES_PER_STEP),
        .ANGLE_STEP       (ANGLE_STEP)
    ) u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .operation     (op_reg),
        .echo_us       (us_reg),
        .cm_est        (cm_est_reg),
        .very_close_cm (very_close_reg),
        .near_cm       (near_reg),
        .result        (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result;
    end

    // Threshold registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            very_close_reg <= 9'd20;
            near_reg       <= 9'd50;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_VERY_CLOSE: very_close_reg <= cfg_data;
                REG_NEAR:       near_reg       <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign servo_angle  = result_reg.servo_angle;
    assign servo_move   = result_reg.servo_move;
    assign left_class   = result_reg.left_class;
    assign right_class  = result_reg.right_class;
    assign center_class = result_reg.center_class;
    assign step_taken   = result_reg.step_taken;
    assign sweep_done   = result_reg.sweep_done;

endmodule

/* tb/ussc_sweep_checker.sv */
// Checker for the sweep sector scanner: predicts every result beat and compares it.
module ussc_sweep_checker #(
    parameter int SAMPLES_PER_STEP = 5,
    parameter int ANGLE_STEP       = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          operation,
    input  logic [ussc_pkg::ECHO_W-1:0]   echo_us,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ussc_pkg::ANGLE_W-1:0]  servo_angle,
    input  logic                          servo_move,
    input  logic [ussc_pkg::CLASS_W-1:0]  left_class,
    input  logic [ussc_pkg::CLASS_W-1:0]  right_class,
    input  logic [ussc_pkg::CLASS_W-1:0]  center_class,
    input  logic                          step_taken,
    input  logic                          sweep_done,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [ussc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ussc_pkg::THR_W-1:0]    cfg_data,
    output int                            mismatches,
    output int                            results_due,
    output int                            results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ussc_pkg::*;

    localparam logic [THR_W-1:0] VERY_CLOSE_RESET = 9'd20;
    localparam logic [THR_W-1:0] NEAR_RESET       = 9'd50;
    localparam int               REPORT_LIMIT     = 10;

    // Shadow copy of the scanner state and thresholds
    logic [ANGLE_W-1:0] angle_now;
    logic [MODE_W-1:0]  mode_now;
    logic [SEC_W-1:0]   sector_now;
    int                 samples_now;
    int                 cm_total;
    logic [CLASS_W-1:0] left_now;
    logic [CLASS_W-1:0] right_now;
    logic [CLASS_W-1:0] center_now;
    logic [THR_W-1:0]   very_close_now;
    logic [THR_W-1:0]   near_now;

    // Predicted scan results, oldest first
    ussc_result_t scan_results_due[$];
    int           fail_total;
    int           checked_total;

    // Apply one input beat to the shadow state and return the result it produces
    function automatic ussc_result_t advance_sweep(input logic op,
                                                   input logic [ECHO_W-1:0] us);
        ussc_result_t       res;
        int                 total;
        logic [SEC_W-1:0]   sector_after;
        logic [CLASS_W-1:0] cls;
        res = '0;
        if (op == OP_START) begin
            angle_now   = ANGLE_HOME;
            mode_now    = MODE_FWD;
            sector_now  = SEC_LEFT;
            samples_now = 0;
            cm_total    = 0;
            res.servo_move = 1'b1;
        end else if (mode_now == MODE_FWD || mode_now == MODE_REV) begin
            total = cm_total + int'(us) / US_PER_CM;
            if (total > int'(SUM_MAX))
                total = int'(SUM_MAX);
            cm_total = total;
            samples_now++;
            if (samples_now >= SAMPLES_PER_STEP) begin
                if (mode_now == MODE_FWD)
                    angle_now = angle_now + ANGLE_W'(ANGLE_STEP);
                else
                    angle_now = angle_now - ANGLE_W'(ANGLE_STEP);
                res.servo_move = (angle_now >= ANGLE_SERVO_MIN) && (angle_now <= ANGLE_SERVO_MAX);
                if (angle_now <= ANGLE_RIGHT_MAX)
                    sector_after = SEC_RIGHT;
                else if (angle_now < ANGLE_LEFT_MIN)
                    sector_after = SEC_CENTER;
                else
                    sector_after = SEC_LEFT;
                // leaving a sector: classify the mean of the step just finished
                if (sector_after != sector_now) begin
                    if (cm_total < SAMPLES_PER_STEP * int'(very_close_now))
                        cls = CLASS_VERY_CLOSE;
                    else if (cm_total < SAMPLES_PER_STEP * int'(near_now))
                        cls = CLASS_NEAR;
                    else
                        cls = CLASS_FAR;
                    if (sector_now == SEC_LEFT)
                        left_now = cls;
                    else if (sector_now == SEC_RIGHT)
                        right_now = cls;
                    else
                        center_now = cls;
                end
                sector_now = sector_after;
                if (mode_now == MODE_FWD) begin
                    if (angle_now >= ANGLE_FWD_END)
                        mode_now = MODE_REV;
                end else if (angle_now <= ANGLE_REV_END) begin
                    mode_now = MODE_IDLE;
                end
                samples_now = 0;
                cm_total    = 0;
                res.step_taken = 1'b1;
            end
        end
        res.servo_angle  = angle_now;
        res.left_class   = left_now;
        res.right_class  = right_now;
        res.center_class = center_now;
        res.sweep_done   = !(mode_now == MODE_FWD || mode_now == MODE_REV);
        return res;
    endfunction

    // Compare one field, report the first few misses
    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("%t: result %0d %s mismatch: expected %0d, got %0d",
                         $time, checked_total, field, want, got);
        end
    endfunction

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n) begin : watch_beats
        ussc_result_t want;
        if (!rst_n) begin
            angle_now      = ANGLE_HOME;
            mode_now       = MODE_IDLE;
            sector_now     = SEC_LEFT;
            samples_now    = 0;
            cm_total       = 0;
            left_now       = CLASS_FAR;
            right_now      = CLASS_FAR;
            center_now     = CLASS_FAR;
            very_close_now = VERY_CLOSE_RESET;
            near_now       = NEAR_RESET;
            scan_results_due.delete();
        end else begin
            // result beat against the oldest prediction
            if (out_valid && out_ready) begin
                if (scan_results_due.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%t: result beat with nothing predicted (angle %0d)",
                                 $time, servo_angle);
                end else begin
                    want = scan_results_due.pop_front();
                    check_field("servo_angle", want.servo_angle, servo_angle);
                    check_field("servo_move", 8'(want.servo_move), 8'(servo_move));
                    check_field("left_class", 8'(want.left_class), 8'(left_class));
                    check_field("right_class", 8'(want.right_class), 8'(right_class));
                    check_field("center_class", 8'(want.center_class), 8'(center_class));
                    check_field("step_taken", 8'(want.step_taken), 8'(step_taken));
                    check_field("sweep_done", 8'(want.sweep_done), 8'(sweep_done));
                end
                checked_total++;
            end
            // threshold writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_VERY_CLOSE)
                    very_close_now = cfg_data;
                else if (cfg_index == REG_NEAR)
                    near_now = cfg_data;
            end
            // input beat: predict its result
            if (in_valid && in_ready)
                scan_results_due.push_back(advance_sweep(operation, echo_us));
        end
        mismatches      <= fail_total;
        results_due     <= scan_results_due.size();
        results_checked <= checked_total;
    end

endmodule

/* tb/tb_ultrasonic_sweep_sector_scanner.sv */
// Testbench top for the sweep sector scanner: stimulus, flow control and verdict.
module tb_ultrasonic_sweep_sector_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import ussc_pkg::*;

    localparam int SAMPLES_PER_STEP = 5;
    localparam int ANGLE_STEP       = 2;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 4;
    localparam int ITEM_TARGET      = 1600;
    localparam int THRESHOLD_SETS   = 6;
    localparam int LONG_HOLD        = 60;
    localparam int FIRST_HOLD_AT    = 350;
    localparam int HOLD_EVERY       = 600;
    localparam int DRAIN_CYCLES     = 4;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_CM           = (2 ** ECHO_W - 1) / US_PER_CM;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                operation = 1'b0;
    logic [ECHO_W-1:0]   echo_us   = '0;
    logic                out_ready = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [THR_W-1:0]    cfg_data  = '0;

    logic                in_ready;
    logic                out_valid;
    logic                cfg_ready;
    logic [ANGLE_W-1:0]  servo_angle;
    logic                servo_move;
    logic [CLASS_W-1:0]  left_class;
    logic [CLASS_W-1:0]  right_class;
    logic [CLASS_W-1:0]  center_class;
    logic                step_taken;
    logic                sweep_done;

    int mismatches;
    int results_due;
    int results_checked;
    int items_sent = 0;

    // thresholds currently programmed, used to aim echo widths
    logic [THR_W-1:0] very_close_set = 9'd20;
    logic [THR_W-1:0] near_set       = 9'd50;

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    ultrasonic_sweep_sector_scanner #(
        .SAMPLES_PER_STEP (SAMPLES_PER_STEP),
        .ANGLE_STEP       (ANGLE_STEP)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .echo_us      (echo_us),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .servo_angle  (servo_angle),
        .servo_move   (servo_move),
        .left_class   (left_class),
        .right_class  (right_class),
        .center_class (center_class),
        .step_taken   (step_taken),
        .sweep_done   (sweep_done),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    ussc_sweep_checker #(
        .SAMPLES_PER_STEP (SAMPLES_PER_STEP),
        .ANGLE_STEP       (ANGLE_STEP)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .echo_us         (echo_us),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .servo_angle     (servo_angle),
        .servo_move      (servo_move),
        .left_class      (left_class),
        .right_class     (right_class),
        .center_class    (center_class),
        .step_taken      (step_taken),
        .sweep_done      (sweep_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .results_due     (results_due),
        .results_checked (results_checked)
    );

    // Gap length: mostly none or short, now and then long
    function automatic int idle_length(input bit steady);
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            n = 0;
        else if (roll < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(8, 30);
        return n;
    endfunction

    // Echo width: full range, the two extremes, or aimed near a threshold
    function automatic logic [ECHO_W-1:0] pick_echo();
        int                roll;
        int                cm;
        int                us;
        logic [ECHO_W-1:0] width;
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
            width = ECHO_W'($urandom);
        end else if (roll < 30) begin
            width = '1;
        end else if (roll < 35) begin
            width = '0;
        end else begin
            cm = (roll < 70) ? int'(very_close_set) : int'(near_set);
            cm = cm + int'($urandom_range(0, 6)) - 3;
            if (cm < 0)
                cm = 0;
            if (cm > MAX_CM)
                cm = MAX_CM;
            us = cm * US_PER_CM + int'($urandom_range(0, US_PER_CM - 1));
            if (us > 2 ** ECHO_W - 1)
                us = 2 ** ECHO_W - 1;
            width = ECHO_W'(us);
        end
        return width;
    endfunction

    // One input beat; valid stays up afterwards unless the caller idles
    task automatic send_beat(input logic op, input logic [ECHO_W-1:0] us);
        in_valid  <= 1'b1;
        operation <= op;
        echo_us   <= us;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Both thresholds in one burst, order random
    task automatic write_thresholds(input logic [THR_W-1:0] vc, input logic [THR_W-1:0] nr);
        logic near_first;
        near_first = 1'($urandom_range(0, 1));
        cfg_valid <= 1'b1;
        cfg_index <= near_first ? REG_NEAR : REG_VERY_CLOSE;
        cfg_data  <= near_first ? nr : vc;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= near_first ? REG_VERY_CLOSE : REG_NEAR;
        cfg_data  <= near_first ? vc : nr;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        very_close_set = vc;
        near_set       = nr;
    endtask

    // Wait until every predicted result has been seen, then let the pipe settle
    task automatic drain_results();
        do @(posedge clk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure plus a long hold every so often
    initial begin : result_sink
        int stall;
        int steady;
        int next_hold_at;
        steady       = 0;
        next_hold_at = FIRST_HOLD_AT;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (items_sent >= next_hold_at) begin
                stall        = LONG_HOLD;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end else begin
                if (steady > 0)
                    steady--;
                else if ($urandom_range(0, 149) == 0)
                    steady = $urandom_range(40, 150);
                stall = idle_length(steady > 0);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no beat on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: %0d cycles without a beat, %0d results outstanding",
                 WATCHDOG_LIMIT, results_due);
        $display("ultrasonic_sweep_sector_scanner regression: fail");
        $finish;
    end

    // Stimulus
    initial begin : stimulus
        logic [ECHO_W-1:0] boundary_widths [5];
        logic [THR_W-1:0]  vc;
        logic [THR_W-1:0]  nr;
        int a;
        int steps;
        int sweep_echoes;
        int echoes_left;
        int quota;
        int counted;
        int gap;
        int steady;
        int n_starts;
        int n_echoes;
        int n_ignored;
        int n_sweeps;

        boundary_widths = '{16'd0, 16'hFFFF, 16'd57, 16'd58, 16'd115};
        n_starts  = 0;
        n_echoes  = 0;
        n_ignored = 0;
        n_sweeps  = 0;
        steady    = 0;

        // echoes in one full sweep: forward to the far end, then back past home
        a     = int'(ANGLE_HOME);
        steps = 0;
        do begin
            a = a + ANGLE_STEP;
            steps++;
        end while (a < int'(ANGLE_FWD_END));
        do begin
            a = a - ANGLE_STEP;
            steps++;
        end while (a > int'(ANGLE_REV_END));
        sweep_echoes = steps * SAMPLES_PER_STEP;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block ignores echoes
        send_beat(OP_ECHO, '1);
        send_beat(OP_ECHO, '0);
        n_ignored = n_ignored + 2;
        // first step: width extremes and the cm rounding boundary, leaving LEFT as far
        send_beat(OP_START, '1);
        foreach (boundary_widths[i])
            send_beat(OP_ECHO, boundary_widths[i]);
        // same-sector step stores nothing
        repeat (SAMPLES_PER_STEP) send_beat(OP_ECHO, 16'd580);
        // restart mid-sweep keeps classes; next step stores LEFT as very close
        send_beat(OP_START, '0);
        repeat (SAMPLES_PER_STEP) send_beat(OP_ECHO, 16'd580);
        n_starts    = 2;
        n_echoes    = 3 * SAMPLES_PER_STEP;
        echoes_left = sweep_echoes - SAMPLES_PER_STEP;

        quota = ITEM_TARGET / THRESHOLD_SETS;
        for (int phase = 0; phase < THRESHOLD_SETS; phase++) begin
            in_valid <= 1'b0;
            drain_results();
            case (phase)
                0: begin vc = '0;      nr = '0;      end
                1: begin vc = THR_MAX; nr = THR_MAX; end
                2: begin vc = '0;      nr = THR_MAX; end
                3: begin vc = THR_MAX; nr = '0;      end
                4: begin
                    vc = THR_W'($urandom_range(0, THR_MAX));
                    nr = THR_W'($urandom_range(0, THR_MAX));
                end
                default: begin
                    vc = THR_W'($urandom_range(0, 100));
                    nr = THR_W'($urandom_range(100, 400));
                end
            endcase
            write_thresholds(vc, nr);

            // mostly full sweeps with random widths, a few restarts and idle echoes
            counted = 0;
            while (counted < quota) begin
                if (echoes_left == 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_beat(OP_ECHO, pick_echo());
                        n_ignored++;
                    end else begin
                        send_beat(OP_START, ECHO_W'($urandom));
                        echoes_left = sweep_echoes;
                        n_starts++;
                        counted++;
                    end
                end else if ($urandom_range(0, 599) == 0) begin
                    send_beat(OP_START, ECHO_W'($urandom));
                    echoes_left = sweep_echoes;
                    n_starts++;
                    counted++;
                end else begin
                    send_beat(OP_ECHO, pick_echo());
                    echoes_left--;
                    n_echoes++;
                    counted++;
                    if (echoes_left == 0)
                        n_sweeps++;
                end
                if (steady > 0)
                    steady--;
                else if ($urandom_range(0, 149) == 0)
                    steady = $urandom_range(40, 150);
                gap = idle_length(steady > 0);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        drain_results();

        $display("covered %0d input beats: %0d starts, %0d echoes in sweeps, %0d idle echoes",
                 items_sent, n_starts, n_echoes, n_ignored);
        $display("%0d full sweeps over %0d threshold settings; %0d results checked, %0d mismatches",
                 n_sweeps, THRESHOLD_SETS + 1, results_checked, mismatches);
        if (mismatches == 0)
            $display("ultrasonic_sweep_sector_scanner regression: pass");
        else
            $display("ultrasonic_sweep_sector_scanner regression: fail");
        $finish;
    end

endmodule

/* sim.f */
hdl/ussc_pkg.sv
hdl/ussc_echo_scale.sv
hdl/ussc_sweep_core.sv
hdl/ultrasonic_sweep_sector_scanner.sv
tb/ussc_sweep_checker.sv
tb/tb_ultrasonic_sweep_sector_scanner.sv
